@@ rtl/ufcc_pkg.sv @@
// Shared types, constants and command/status structs of the union-find block.
package ufcc_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int VTX_W            = 8;
  localparam int CNT_W            = 9;
  localparam logic [CNT_W-1:0] NV_RESET = 9'd256;

  typedef struct packed {
    logic             new_list;
    logic [VTX_W-1:0] first_vertex;
    logic [VTX_W-1:0] second_vertex;
  } ufcc_in_t;

  typedef struct packed {
    logic             closes_cycle;
    logic             any_cycle;
    logic [CNT_W-1:0] component_count;
    logic             bad_vertex;
  } ufcc_out_t;

  typedef logic [CNT_W-1:0] ufcc_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_FINISH
  } ufcc_state_e;

  typedef struct packed {
    logic load;        // latch edge, apply new-list init
    logic check;       // range check, point walker at first endpoint
    logic rd;          // read parent of walker
    logic walk;        // walker <= parent
    logic found;       // root found, rewind walker for compression
    logic sel_b;       // current search is for the second endpoint
    logic comp_wr;     // point walker entry at root, advance
    logic next_phase;  // save first root, start second search
    logic finish;      // link roots, update counters, load result
  } ufcc_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_root;
    logic at_root;
    logic out_free;
  } ufcc_sts_t;

endpackage

@@ rtl/ufcc_chan_if.sv @@
// Valid/ready channel carrying one payload beat.
interface ufcc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ufcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ufcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/ufcc_ctrl.sv @@
// Sequencer: accept, range check, two root searches with compression, link.
module ufcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ufcc_pkg::ufcc_sts_t sts_i,
  output ufcc_pkg::ufcc_cmd_t cmd_o
);
  import ufcc_pkg::*;

  ufcc_state_e state_q, state_d;
  logic        phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        phase_d = 1'b0;
        state_d = sts_i.bad ? ST_FINISH : ST_FIND_RD;
      end
      ST_FIND_RD: state_d = ST_FIND_CHK;
      ST_FIND_CHK: begin
        state_d = sts_i.is_root ? ST_COMP_RD : ST_FIND_RD;
      end
      ST_COMP_RD: begin
        if (sts_i.at_root) begin
          if (!phase_q) begin
            phase_d = 1'b1;
            state_d = ST_FIND_RD;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          state_d = ST_COMP_WR;
        end
      end
      ST_COMP_WR: state_d = ST_COMP_RD;
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.sel_b = phase_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK:    cmd_o.check = 1'b1;
      ST_FIND_RD:  cmd_o.rd = 1'b1;
      ST_FIND_CHK: begin
        if (sts_i.is_root) cmd_o.found = 1'b1;
        else cmd_o.walk = 1'b1;
      end
      ST_COMP_RD: begin
        if (sts_i.at_root) cmd_o.next_phase = !phase_q;
        else cmd_o.rd = 1'b1;
      end
      ST_COMP_WR:  cmd_o.comp_wr = 1'b1;
      ST_FINISH:   cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end

  // Second search starts right after the first root is saved.
  a_phase_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q) |-> state_q == ST_FIND_RD)
    else $error("second search did not start with a read");

  // Only a range-failed edge skips the searches.
  a_bad_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && state_d == ST_FINISH) |-> sts_i.bad)
    else $error("search skipped on a good edge");
endmodule

@@ rtl/ufcc_dpath.sv @@
// Datapath: vertex-count register, parent table with valid bits, walker, counters.
module ufcc_dpath #(
  parameter int MAX_VERTICES = ufcc_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ufcc_pkg::ufcc_cmd_t cmd_i,
  output ufcc_pkg::ufcc_sts_t sts_o,
  input  ufcc_pkg::ufcc_in_t  in_data_i,
  input  logic                cfg_valid_i,
  input  ufcc_pkg::ufcc_cfg_t cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output ufcc_pkg::ufcc_out_t out_data_o
);
  import ufcc_pkg::*;

  // Endpoints are VTX_W bits wide, so no entry beyond that range is ever touched.
  localparam int TABLE_DEPTH = (MAX_VERTICES < (1 << VTX_W)) ? MAX_VERTICES : (1 << VTX_W);
  localparam int AW          = $clog2(TABLE_DEPTH);

  logic [CNT_W-1:0]       nv_q;
  logic [VTX_W-1:0]       a_q, b_q;
  logic [AW-1:0]          cur_q, root_q, x_q;
  logic                   bad_q;
  logic                   cycle_q, cycle_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [TABLE_DEPTH-1:0] vld_q, vld_d;
  logic                   rvld_q;
  logic                   out_valid_q;
  ufcc_out_t              out_q;

  logic [CNT_W-1:0] act_cnt;
  logic [AW-1:0]    ram_rdata, parent;
  logic             we;
  logic [AW-1:0]    waddr, wdata;
  logic             same_root, do_link, clear;

  assign act_cnt = (32'(nv_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : nv_q;
  assign parent  = rvld_q ? ram_rdata : cur_q;
  assign same_root = (x_q == root_q);
  assign do_link = cmd_i.finish && !bad_q && !same_root;
  assign clear   = cmd_i.load && in_data_i.new_list;

  assign we    = cmd_i.comp_wr || do_link;
  assign waddr = cmd_i.comp_wr ? cur_q : root_q;
  assign wdata = cmd_i.comp_wr ? root_q : x_q;

  assign sts_o.bad      = (CNT_W'(a_q) >= act_cnt) || (CNT_W'(b_q) >= act_cnt);
  assign sts_o.is_root  = (parent == cur_q);
  assign sts_o.at_root  = (cur_q == root_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  ufcc_ram #(
    .WIDTH (AW),
    .DEPTH (TABLE_DEPTH)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (cur_q),
    .rdata_o (ram_rdata)
  );

  // Entry without a valid bit reads as its own index.
  always_comb begin
    vld_d = vld_q;
    if (clear) vld_d = '0;
    if (we) vld_d[waddr] = 1'b1;
  end

  always_comb begin
    cycle_d = cycle_q;
    cnt_d   = cnt_q;
    if (clear) begin
      cycle_d = 1'b0;
      cnt_d   = act_cnt;
    end else if (cmd_i.finish && !bad_q) begin
      if (same_root) cycle_d = 1'b1;
      else if (cnt_q != '0) cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q        <= NV_RESET;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      cycle_q     <= 1'b0;
      cnt_q       <= (32'(NV_RESET) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : NV_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) nv_q <= cfg_data_i;
      vld_q   <= vld_d;
      cycle_q <= cycle_d;
      cnt_q   <= cnt_d;
      if (cmd_i.rd) rvld_q <= vld_q[cur_q];
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= in_data_i.first_vertex;
      b_q <= in_data_i.second_vertex;
    end
    if (cmd_i.check) begin
      bad_q <= sts_o.bad;
      cur_q <= AW'(a_q);
    end
    if (cmd_i.walk || cmd_i.comp_wr) cur_q <= parent;
    if (cmd_i.found) begin
      root_q <= cur_q;
      cur_q  <= cmd_i.sel_b ? AW'(b_q) : AW'(a_q);
    end
    if (cmd_i.next_phase) begin
      x_q   <= root_q;
      cur_q <= AW'(b_q);
    end
    if (cmd_i.finish) begin
      out_q.closes_cycle    <= !bad_q && same_root;
      out_q.any_cycle       <= cycle_d;
      out_q.component_count <= cnt_d;
      out_q.bad_vertex      <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending beat");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> !we)
    else $error("table read and write in one cycle");

  a_count_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > $past(cnt_q)) |-> $past(cmd_i.load))
    else $error("component count rose outside a new list");
endmodule

@@ rtl/union_find_cycle_components.sv @@
// Top level of the union-find edge processor: channels, sequencer and datapath.
//
//   channel  dir  modport  beat contents
//   in_i     in   sink     new_list, first_vertex, second_vertex
//   out_o    out  source   closes_cycle, any_cycle, component_count, bad_vertex
//   cfg_i    in   sink     num_vertices (always ready)
//
// One edge at a time. Each endpoint is walked to its root and its path is then
// compressed; an out-of-range edge skips both searches. The single table RAM
// port pair (one read, one write) serialises these steps.
// A new list clears the table's valid bits in the accept cycle; no sweep.
// A result waiting on out_o holds the next edge only at its final step.
module union_find_cycle_components #(
  parameter int MAX_VERTICES = ufcc_pkg::MAX_VERTICES_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  ufcc_chan_if.sink   in_i,
  ufcc_chan_if.source out_o,
  ufcc_chan_if.sink   cfg_i
);
  import ufcc_pkg::*;

  ufcc_cmd_t cmd;
  ufcc_sts_t sts;
  logic      in_ready;
  logic      out_valid;
  ufcc_out_t out_data;

  ufcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ufcc_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;
endmodule
